// ===== design/mtht_pkg.sv =====
// Mode transition history table: shared package.
// Holds sizes, request and status codes, and the types passed between modules.
// Depends on nothing.
`timescale 1ns / 1ps

package mtht_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int MODE_BITS     = 8;

    localparam int SLOT_W     = $clog2(HISTORY_DEPTH);
    localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
    localparam int ITER_W     = 31;
    localparam int MODE_OUT_W = 8;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [REQ_W-1:0] REQ_UPDATE     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY_CUR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY_NEXT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_NEXT   = 2'd2;

    typedef struct packed {
        logic [ITER_W-1:0]    iter;
        logic [MODE_BITS-1:0] mode;
    } hist_entry_t;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_W-1:0]    wr_slot;
        hist_entry_t          wr_data;
        logic [SLOT_W-1:0]    rd_slot;
    } mem_ctl_t;

    typedef struct packed {
        logic                  valid;
        logic [STATUS_W-1:0]   status;
        logic [MODE_OUT_W-1:0] mode;
        logic [ITER_W-1:0]     start;
        logic                  state;
    } result_t;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic                  new_state;
        logic [ITER_W-1:0]     iteration;
        logic [MODE_OUT_W-1:0] next_mode;
    } request_t;

endpackage

// ===== design/mtht_hist_mem.sv =====
// Mode transition history table: history entry memory.
// One write port, one read port with registered read data; no reset.
// Depends on mtht_pkg.
`timescale 1ns / 1ps

module mtht_hist_mem
(
    input  logic                     clk,
    input  mtht_pkg::mem_ctl_t       ctl,
    output mtht_pkg::hist_entry_t    rd_data
);
    import mtht_pkg::*;

    hist_entry_t mem_reg [HISTORY_DEPTH];
    hist_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[ctl.wr_slot] <= ctl.wr_data;
        end
        rd_data_reg <= mem_reg[ctl.rd_slot];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/mtht_seq.sv =====
// Mode transition history table: request sequencer.
// Holds ring pointers and mode state, runs the backward search with one
// shared compare unit over the history memory. Depends on mtht_pkg.
`timescale 1ns / 1ps

module mtht_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  mtht_pkg::request_t     req,
    input  mtht_pkg::hist_entry_t  rd_data,
    output mtht_pkg::mem_ctl_t     mem_ctl,
    output mtht_pkg::result_t      res,
    output logic                   idle
);
    import mtht_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FETCH = 4'b0100,
        S_TAKE  = 4'b1000
    } seq_state_t;

    seq_state_t           state_reg, state_next;
    logic [SLOT_W-1:0]    oldest_reg, oldest_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [MODE_BITS-1:0] cur_mode_reg, cur_mode_next;
    logic                 flag_reg, flag_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [ITER_W-1:0]    key_reg, key_next;
    logic [SLOT_W-1:0]    rd_pos_reg, rd_pos_next;
    logic [SLOT_W-1:0]    cmp_pos_reg, cmp_pos_next;
    logic                 cmp_valid_reg, cmp_valid_next;

    logic [MODE_BITS-1:0] req_mode;
    logic                 record;
    logic                 hit;
    logic [CNT_W-1:0]     nxt_pos;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(HISTORY_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(HISTORY_DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    assign req_mode = MODE_BITS'(req.next_mode);
    assign record   = !flag_reg && req.new_state &&
                      ((cur_mode_reg != req_mode) || (req.iteration == '0));
    assign hit      = cmp_valid_reg && (rd_data.iter <= key_reg);
    assign nxt_pos  = CNT_W'(cmp_pos_reg) + CNT_W'(1);
    assign idle     = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        cur_mode_next  = cur_mode_reg;
        flag_next      = flag_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        rd_pos_next    = rd_pos_reg;
        cmp_pos_next   = cmp_pos_reg;
        cmp_valid_next = cmp_valid_reg;

        mem_ctl.wr_en   = 1'b0;
        mem_ctl.wr_slot = slot_of(oldest_reg, count_reg);
        mem_ctl.wr_data = '{iter: req.iteration, mode: req_mode};
        mem_ctl.rd_slot = slot_of(oldest_reg, CNT_W'(rd_pos_reg));

        res.valid  = 1'b0;
        res.status = ST_OK;
        res.mode   = '0;
        res.start  = '0;
        res.state  = flag_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next       = req.req_type;
                    key_next       = req.iteration;
                    rd_pos_next    = SLOT_W'(count_reg - CNT_W'(1));
                    cmp_valid_next = 1'b0;
                    case (req.req_type)
                        REQ_UPDATE:
                        begin
                            if (record)
                            begin
                                cur_mode_next = req_mode;
                                mem_ctl.wr_en = 1'b1;
                                if (count_reg < CNT_W'(HISTORY_DEPTH))
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    mem_ctl.wr_slot = oldest_reg;
                                    oldest_next     = slot_of(oldest_reg, CNT_W'(1));
                                end
                            end
                            flag_next = req.new_state;
                            res.valid = 1'b1;
                            res.mode  = MODE_OUT_W'(cur_mode_next);
                            res.state = req.new_state;
                        end
                        REQ_CLEAR:
                        begin
                            oldest_next   = '0;
                            count_next    = '0;
                            cur_mode_next = '0;
                            flag_next     = 1'b0;
                            res.valid     = 1'b1;
                            res.state     = 1'b0;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res.valid = 1'b1;
                                if (req.iteration != '0)
                                begin
                                    res.status = ST_NOT_FOUND;
                                end
                                else if (req.req_type == REQ_QUERY_NEXT)
                                begin
                                    res.status = ST_NO_NEXT;
                                end
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmp_pos_next   = rd_pos_reg;
                rd_pos_next    = rd_pos_reg - SLOT_W'(1);
                cmp_valid_next = 1'b1;
                if (hit)
                begin
                    if (req_reg == REQ_QUERY_CUR)
                    begin
                        res.valid  = 1'b1;
                        res.mode   = MODE_OUT_W'(rd_data.mode);
                        state_next = S_IDLE;
                    end
                    else if (nxt_pos >= count_reg)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_NO_NEXT;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_pos_next = SLOT_W'(nxt_pos);
                        state_next  = S_FETCH;
                    end
                end
                else if (cmp_valid_reg && (cmp_pos_reg == '0))
                begin
                    if (key_reg != '0)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                    else if (req_reg == REQ_QUERY_CUR)
                    begin
                        res.valid  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_pos_next = '0;
                        state_next  = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                res.valid  = 1'b1;
                res.mode   = MODE_OUT_W'(rd_data.mode);
                res.start  = rd_data.iter;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            cur_mode_reg  <= '0;
            flag_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            cur_mode_reg  <= cur_mode_next;
            flag_reg      <= flag_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        rd_pos_reg  <= rd_pos_next;
        cmp_pos_reg <= cmp_pos_next;
    end

endmodule

// ===== design/mode_transition_history_table.sv =====
// Mode transition history table, top level. Updates, clears and queries on an
// empty history: result registered in the cycle after the item. Queries walk back
// one entry a cycle through the history memory; a next-mode query then reads the
// following entry through the fetch and take states.
// One item at a time. Reset empties the history, mode 0, state transiting.
`timescale 1ns / 1ps

module mode_transition_history_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mtht_pkg::REQ_W-1:0]          req_type,
    input  logic                                new_state,
    input  logic [mtht_pkg::ITER_W-1:0]         iteration,
    input  logic [mtht_pkg::MODE_OUT_W-1:0]     next_mode,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mtht_pkg::STATUS_W-1:0]       status,
    output logic [mtht_pkg::MODE_OUT_W-1:0]     mode_index,
    output logic [mtht_pkg::ITER_W-1:0]         start_iteration,
    output logic                                mode_state
);
    import mtht_pkg::*;

    request_t    req;
    result_t     seq_res;
    mem_ctl_t    mem_ctl;
    hist_entry_t rd_data;
    logic        seq_idle;
    logic        in_acc;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [MODE_OUT_W-1:0] mode_reg;
    logic [ITER_W-1:0]     start_reg;
    logic                  state_reg;

    assign req      = '{req_type: req_type, new_state: new_state,
                        iteration: iteration, next_mode: next_mode};
    assign in_ready = seq_idle && (!out_valid_reg || out_ready);
    assign in_acc   = in_valid && in_ready;

    mtht_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_acc),
        .req     (req),
        .rd_data (rd_data),
        .mem_ctl (mem_ctl),
        .res     (seq_res),
        .idle    (seq_idle)
    );

    mtht_hist_mem u_mem
    (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res.valid)
        begin
            status_reg <= seq_res.status;
            mode_reg   <= seq_res.mode;
            start_reg  <= seq_res.start;
            state_reg  <= seq_res.state;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign mode_index      = mode_reg;
    assign start_iteration = start_reg;
    assign mode_state      = state_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        seq_res.valid |-> (!out_valid_reg || out_ready))
        else $error("result overwrites an item not yet taken");

    a_late_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_res.valid && !in_acc) |-> !seq_idle)
        else $error("result produced with no item in progress");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_res.valid && seq_idle) |=> !seq_res.valid || in_acc)
        else $error("second result without a new item");

endmodule
